// ===== hdl/scso_pkg.sv =====
// Package: shared types, register indexes and reset values for the sine oscillator.
`timescale 1ns / 1ps
`default_nettype none
package scso_pkg;

  localparam int CODE_W = 16;
  localparam int SLOPE_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIFF_W = CODE_W + 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_CODE_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HZ_PER_CODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_LOW_HZ    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_HIGH_HZ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CODE_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_PER_CODE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PER_HZ    = 3'd6;

  // Register reset values
  localparam logic [CODE_W-1:0]  RST_PITCH_CODE_LOW = 16'd655;
  localparam logic [SLOPE_W-1:0] RST_HZ_PER_CODE    = 24'd2093;
  localparam logic [CODE_W-1:0]  RST_FREQ_LOW_HZ    = 16'd100;
  localparam logic [CODE_W-1:0]  RST_FREQ_HIGH_HZ   = 16'd1000;
  localparam logic [CODE_W-1:0]  RST_GAIN_CODE_LOW  = 16'd9861;
  localparam logic [CODE_W-1:0]  RST_AMP_PER_CODE   = 16'd2047;
  localparam logic [SLOPE_W-1:0] RST_STEP_PER_HZ    = 24'd97392;

  // pi/2 in Q30, full scale of one amplitude unit in Q1.15
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [23:0] AMP_ONE = 24'd32768;

  typedef struct packed {
    logic [CODE_W-1:0]  pitch_code_low;
    logic [SLOPE_W-1:0] hz_per_code;
    logic [CODE_W-1:0]  freq_low_hz;
    logic [CODE_W-1:0]  freq_high_hz;
    logic [CODE_W-1:0]  gain_code_low;
    logic [CODE_W-1:0]  amp_per_code;
    logic [SLOPE_W-1:0] step_per_hz;
  } cfg_t;

  // One classified frame: signed pitch offset, gain offset clipped at zero
  typedef struct packed {
    logic signed [DIFF_W-1:0] pdiff;
    logic [CODE_W-1:0]        gdiff_pos;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FREQ,
    BK_AMP,
    BK_SINE,
    BK_INC_HI,
    BK_INC_LO,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

// ===== hdl/sensor_controlled_sine_oscillator.sv =====
// Top level: sensor-driven sine oscillator, front end, queue and back end.
// Path: queue, then back-end states FREQ, AMP, SINE, INC_HI, INC_LO, DONE.
//   The back end starts a frame only after DONE, as the five products go
//   one after another through the single shared 18x25 multiplier.
// Reset (rst_n, synchronous, active low): phase to zero, registers to
//   their defaults, queue and output emptied; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module sensor_controlled_sine_oscillator #(
  parameter int SINE_TABLE_BITS = 10,  // 6..14, ROM has 2^(bits-2)+1 words
  parameter int PHASE_BITS = 32        // 16..32, phase accumulator width
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [scso_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scso_pkg::CFG_DATA_W-1:0]  cfg_data,
  // frame input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [scso_pkg::CODE_W-1:0]      in_pitch_code,
  input  wire logic [scso_pkg::CODE_W-1:0]      in_gain_code,
  // sample output channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [15:0]                    out_sample
);
  import scso_pkg::*;

  cfg_t   cfg;
  entry_t q_entry;
  entry_t q_head;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;

  // Front end: register file plus offset subtraction of each frame.
  // Input transfer pushes straight into the queue.
  scso_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pitch_code (in_pitch_code),
    .in_gain_code  (in_gain_code),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry),
    .cfg           (cfg)
  );

  // Two frames of slack so input keeps flowing while the back end works
  scso_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  // Back end: freq clamp, amp saturate, sine lookup, scale, phase step.
  // Output register holds one finished sample; back end waits only if
  // that slot is still occupied when the next sample is done.
  scso_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample)
  );

endmodule
`default_nettype wire

// ===== hdl/scso_front.sv =====
// Front end: configuration registers, input handshake and offset classification.
`timescale 1ns / 1ps
`default_nettype none
module scso_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [scso_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scso_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [scso_pkg::CODE_W-1:0]      in_pitch_code,
  input  wire logic [scso_pkg::CODE_W-1:0]      in_gain_code,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output scso_pkg::entry_t                      q_entry,
  output scso_pkg::cfg_t                        cfg
);
  import scso_pkg::*;

  cfg_t cfg_r;
  logic signed [DIFF_W-1:0] gdiff;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pitch_code_low <= RST_PITCH_CODE_LOW;
      cfg_r.hz_per_code    <= RST_HZ_PER_CODE;
      cfg_r.freq_low_hz    <= RST_FREQ_LOW_HZ;
      cfg_r.freq_high_hz   <= RST_FREQ_HIGH_HZ;
      cfg_r.gain_code_low  <= RST_GAIN_CODE_LOW;
      cfg_r.amp_per_code   <= RST_AMP_PER_CODE;
      cfg_r.step_per_hz    <= RST_STEP_PER_HZ;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PITCH_CODE_LOW: cfg_r.pitch_code_low <= cfg_data[CODE_W-1:0];
        REG_HZ_PER_CODE:    cfg_r.hz_per_code    <= cfg_data[SLOPE_W-1:0];
        REG_FREQ_LOW_HZ:    cfg_r.freq_low_hz    <= cfg_data[CODE_W-1:0];
        REG_FREQ_HIGH_HZ:   cfg_r.freq_high_hz   <= cfg_data[CODE_W-1:0];
        REG_GAIN_CODE_LOW:  cfg_r.gain_code_low  <= cfg_data[CODE_W-1:0];
        REG_AMP_PER_CODE:   cfg_r.amp_per_code   <= cfg_data[CODE_W-1:0];
        REG_STEP_PER_HZ:    cfg_r.step_per_hz    <= cfg_data[SLOPE_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  assign in_ready = !q_full;
  assign q_push = in_valid && in_ready;

  always_comb begin
    q_entry.pdiff = $signed({1'b0, in_pitch_code}) - $signed({1'b0, cfg_r.pitch_code_low});
    gdiff = $signed({1'b0, in_gain_code}) - $signed({1'b0, cfg_r.gain_code_low});
    // gain at or below its low mark means silence
    q_entry.gdiff_pos = gdiff[DIFF_W-1] ? '0 : gdiff[CODE_W-1:0];
  end

endmodule
`default_nettype wire

// ===== hdl/scso_queue.sv =====
// Two-entry queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module scso_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire scso_pkg::entry_t  push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   valid,
  output scso_pkg::entry_t       head
);
  import scso_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/scso_back.sv =====
// Back end: multiply sequencer, frequency/amplitude mapping, sine ROM, phase and output.
`timescale 1ns / 1ps
`default_nettype none
module scso_back #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scso_pkg::cfg_t    cfg,
  input  wire logic              q_valid,
  input  wire scso_pkg::entry_t  q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [15:0]     out_sample
);
  import scso_pkg::*;

  localparam int QSIZE = 1 << (SINE_TABLE_BITS - 2);
  localparam int IDX_W = SINE_TABLE_BITS - 1;
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 25;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  typedef logic [14:0] tab_t [0:QSIZE];

  // Quarter-wave table, round(32767*sin) from a Q30 Taylor series
  function automatic tab_t build_tab();
    tab_t t;
    logic [63:0] x, x2, term, pos, neg, s, v;
    for (int i = 0; i <= QSIZE; i++) begin
      x = (HALF_PI_Q30 * 64'(i)) / QSIZE;
      x2 = (x * x) >> 30;
      term = x;
      pos = x;
      neg = 64'd0;
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) neg = neg + term;
        else pos = pos + term;
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      t[i] = v[14:0];
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  back_state_t state_r, state_nxt;

  logic signed [DIFF_W-1:0]  pdiff_r;
  logic [CODE_W-1:0]         gdiff_r;
  logic [31:0]               freq_r, freq_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_en;
  logic [15:0]               smp_r, smp_nxt;
  logic [PHASE_BITS-1:0]     inc_hi_r;
  logic [PHASE_BITS-1:0]     phase_acc_r, phase_acc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [15:0]               out_sample_r;
  logic                      out_load;
  logic [14:0]               rom_r;

  logic [SINE_TABLE_BITS-1:0] ph_n;
  logic [1:0]                 quad;
  logic [IDX_W-1:0]           tab_idx;
  logic [40:0]                freq_sum, lo_ext, hi_ext;
  logic [23:0]                amp_raw;
  logic [15:0]                amp;
  logic [14:0]                mag;

  // Phase only moves at BK_DONE, so the ROM output settles long before BK_SINE
  always_comb begin
    ph_n = phase_acc_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
    quad = ph_n[SINE_TABLE_BITS-1 -: 2];
    tab_idx = {1'b0, ph_n[SINE_TABLE_BITS-3:0]};
    if (quad[0]) tab_idx = IDX_W'(QSIZE) - tab_idx;
  end

  always_ff @(posedge clk) begin
    rom_r <= SINE_TAB[tab_idx];
  end

  // Product decoding
  always_comb begin
    lo_ext = {9'd0, cfg.freq_low_hz, 16'd0};
    hi_ext = {9'd0, cfg.freq_high_hz, 16'd0};
    freq_sum = lo_ext + prod_r[40:0];
    if (prod_r[PROD_W-1]) freq_nxt = lo_ext[31:0];
    else if (freq_sum > hi_ext) freq_nxt = hi_ext[31:0];
    else freq_nxt = freq_sum[31:0];

    amp_raw = prod_r[31:8];
    amp = (amp_raw > AMP_ONE) ? AMP_ONE[15:0] : amp_raw[15:0];

    mag = prod_r[29:15];
    smp_nxt = quad[1] ? 16'(-{1'b0, mag}) : {1'b0, mag};
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_en = 1'b1;
    case (state_r)
      BK_FREQ: begin
        mul_a = MUL_A_W'(pdiff_r);
        mul_b = {1'b0, cfg.hz_per_code};
      end
      BK_AMP: begin
        mul_a = {2'b00, gdiff_r};
        mul_b = {1'b0, 8'd0, cfg.amp_per_code};
      end
      BK_SINE: begin
        mul_a = {2'b00, amp};
        mul_b = {10'd0, rom_r};
      end
      BK_INC_HI: begin
        mul_a = {2'b00, freq_r[31:16]};
        mul_b = {1'b0, cfg.step_per_hz};
      end
      BK_INC_LO: begin
        mul_a = {2'b00, freq_r[15:0]};
        mul_b = {1'b0, cfg.step_per_hz};
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_a * mul_b;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    q_pop = 1'b0;
    out_load = 1'b0;
    phase_acc_nxt = phase_acc_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_nxt = BK_FREQ;
        end
      end
      BK_FREQ:   state_nxt = BK_AMP;
      BK_AMP:    state_nxt = BK_SINE;
      BK_SINE:   state_nxt = BK_INC_HI;
      BK_INC_HI: state_nxt = BK_INC_LO;
      BK_INC_LO: state_nxt = BK_DONE;
      BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          phase_acc_nxt = phase_acc_r + inc_hi_r + PHASE_BITS'(prod_r[PROD_W-1:16]);
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      phase_acc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_acc_r <= phase_acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pdiff_r <= q_head.pdiff;
      gdiff_r <= q_head.gdiff_pos;
    end
    if (state_r == BK_AMP) freq_r <= freq_nxt;
    if (state_r == BK_INC_HI) smp_r <= smp_nxt;
    if (state_r == BK_INC_LO) inc_hi_r <= prod_r[PHASE_BITS-1:0];
    if (out_load) out_sample_r <= smp_r;
  end

  assign out_valid = out_valid_r;
  assign out_sample = $signed(out_sample_r);

endmodule
`default_nettype wire

// ===== tb/sv/scso_sample_checker.sv =====
// Checker: watches all three channels, predicts each sample and compares it.
`timescale 1ns / 1ps
module scso_sample_checker #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [scso_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scso_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  input  wire logic                             in_ready,
  input  wire logic [scso_pkg::CODE_W-1:0]      in_pitch_code,
  input  wire logic [scso_pkg::CODE_W-1:0]      in_gain_code,
  input  wire logic                             out_valid,
  input  wire logic                             out_ready,
  input  wire logic signed [15:0]               out_sample,
  output int                                    fail_count,
  output int                                    pending
);
  import scso_pkg::*;

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam longint unsigned PHASE_MASK = (64'd1 << PHASE_BITS) - 64'd1;
  localparam int PRINT_CAP = 100;

  logic [15:0]          quarter_sine [0:QUARTER];
  cfg_t                 regs;
  longint unsigned      phase_acc;
  logic signed [15:0]   expected_samples [$];
  int                   sample_no;

  // sin(x) in Q30 for 0 <= x <= pi/2, integer Taylor series to x^17
  function automatic longint unsigned sine_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned dv;
    int k;
    x2 = (x * x) >> 30;
    term = x;
    pos = x;
    neg = 64'd0;
    for (k = 1; k <= 8; k++) begin
      dv = longint'(2 * k * (2 * k + 1));
      term = ((term * x2) >> 30) / dv;
      if (k % 2 == 1) neg += term;
      else pos += term;
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  initial begin : build_sine
    longint unsigned i;
    longint unsigned s;
    longint unsigned v;
    for (i = 0; i <= QUARTER; i++) begin
      s = sine_q30((HALF_PI_Q30 * i) / QUARTER);
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      quarter_sine[i] = v[15:0];
    end
  end

  // Sample for the current phase, then advance the phase
  function automatic logic signed [15:0] next_sample(input logic [15:0] pitch,
                                                     input logic [15:0] gain);
    longint p_code, g_code, pdiff, gdiff, lo, hi, slope, freq;
    longint unsigned amp, n, quad, k, mag, sine, step;
    p_code = longint'(pitch);
    g_code = longint'(gain);
    pdiff = p_code - longint'(regs.pitch_code_low);
    gdiff = g_code - longint'(regs.gain_code_low);
    lo = longint'(regs.freq_low_hz) << 16;
    hi = longint'(regs.freq_high_hz) << 16;
    slope = longint'(regs.hz_per_code);
    freq = lo + pdiff * slope;
    if (freq < lo) freq = lo;
    else if (freq > hi) freq = hi;

    if (gdiff <= 0) begin
      amp = 64'd0;
    end else begin
      amp = longint'(gdiff * longint'(regs.amp_per_code)) >> 8;
      if (amp > 64'(AMP_ONE)) amp = 64'(AMP_ONE);
    end

    n = (phase_acc & PHASE_MASK) >> (PHASE_BITS - SINE_TABLE_BITS);
    quad = (n >> (SINE_TABLE_BITS - 2)) & 64'd3;
    k = n & 64'(QUARTER - 1);
    sine = 64'(quad[0] ? quarter_sine[QUARTER - k] : quarter_sine[k]);
    mag = (amp * sine) >> 15;

    step = 64'(regs.step_per_hz);
    phase_acc = (phase_acc + ((longint'(freq) * step) >> 16)) & PHASE_MASK;
    return quad[1] ? -$signed(mag[15:0]) : $signed(mag[15:0]);
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst_n) begin
      regs.pitch_code_low = RST_PITCH_CODE_LOW;
      regs.hz_per_code    = RST_HZ_PER_CODE;
      regs.freq_low_hz    = RST_FREQ_LOW_HZ;
      regs.freq_high_hz   = RST_FREQ_HIGH_HZ;
      regs.gain_code_low  = RST_GAIN_CODE_LOW;
      regs.amp_per_code   = RST_AMP_PER_CODE;
      regs.step_per_hz    = RST_STEP_PER_HZ;
      phase_acc = 64'd0;
      expected_samples.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("sample %0d = %0d with nothing expected",
                                    sample_no, out_sample));
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want)
            report_mismatch($sformatf("sample %0d: got %0d, want %0d",
                                      sample_no, out_sample, want));
        end
        sample_no++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PITCH_CODE_LOW: regs.pitch_code_low = cfg_data[CODE_W-1:0];
          REG_HZ_PER_CODE:    regs.hz_per_code    = cfg_data[SLOPE_W-1:0];
          REG_FREQ_LOW_HZ:    regs.freq_low_hz    = cfg_data[CODE_W-1:0];
          REG_FREQ_HIGH_HZ:   regs.freq_high_hz   = cfg_data[CODE_W-1:0];
          REG_GAIN_CODE_LOW:  regs.gain_code_low  = cfg_data[CODE_W-1:0];
          REG_AMP_PER_CODE:   regs.amp_per_code   = cfg_data[CODE_W-1:0];
          REG_STEP_PER_HZ:    regs.step_per_hz    = cfg_data[SLOPE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_samples.push_back(next_sample(in_pitch_code, in_gain_code));
      pending <= expected_samples.size();
    end
  end

endmodule

// ===== tb/sv/sensor_controlled_sine_oscillator_tb.sv =====
// Testbench top: clock, reset, frame and register stimulus, and the verdict.
`timescale 1ns / 1ps
module sensor_controlled_sine_oscillator_tb;
  import scso_pkg::*;

  // Index past the end of the register map; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_PHASES = 8;
  localparam int FRAMES_PER_PHASE = 232;
  localparam int LONG_HOLD = 400;

  // Setting draw styles
  localparam int MODE_TYPICAL = 0;
  localparam int MODE_RANDOM = 1;
  localparam int MODE_EXTREME = 2;
  localparam int MODE_MIXED = 3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic [CODE_W-1:0]      in_pitch_code = '0;
  logic [CODE_W-1:0]      in_gain_code = '0;
  logic                   out_ready = 1'b0;
  wire logic              cfg_ready;
  wire logic              in_ready;
  wire logic              out_valid;
  wire logic signed [15:0] out_sample;

  int fail_count;
  int pending;
  int frames_sent = 0;
  int settings_count = 1;  // reset defaults count as the first setting
  bit tx_burst = 1'b0;
  // Low marks currently programmed, used to aim codes at the mapping knees
  logic [CODE_W-1:0] pitch_low_seen = RST_PITCH_CODE_LOW;
  logic [CODE_W-1:0] gain_low_seen = RST_GAIN_CODE_LOW;

  sensor_controlled_sine_oscillator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pitch_code(in_pitch_code),
    .in_gain_code (in_gain_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample)
  );

  scso_sample_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pitch_code(in_pitch_code),
    .in_gain_code (in_gain_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Handshake waits look at ready on the falling edge, where it is settled,
  // and the transfer itself lands on the following rising edge.

  // One register transfer; a spare wait on the clock after it keeps the next
  // raise of cfg_valid out of the time step that lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_PITCH_CODE_LOW) pitch_low_seen = val[CODE_W-1:0];
    if (idx == REG_GAIN_CODE_LOW) gain_low_seen = val[CODE_W-1:0];
  endtask

  // One frame transfer. Valid stays high on return so that a zero gap gives
  // back-to-back frames; the caller lowers it when the stream stops.
  task automatic send_frame(input logic [CODE_W-1:0] pitch,
                            input logic [CODE_W-1:0] gain);
    int gap;
    if (frames_sent % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pitch_code <= pitch;
    in_gain_code  <= gain;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    frames_sent++;
  endtask

  // Stop sending and let every predicted sample come out; registers may only
  // change once the block has gone quiet.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Value for one register: plausible audio settings, raw 24-bit noise
  // (the 16-bit registers keep only its low 16 bits), or the two ends.
  function automatic logic [CFG_DATA_W-1:0] draw_setting(
      input logic [CFG_IDX_W-1:0] idx, input int mode);
    logic [CFG_DATA_W-1:0] v;
    if (mode == MODE_MIXED) mode = $urandom_range(MODE_TYPICAL, MODE_EXTREME);
    v = '0;
    if (mode == MODE_RANDOM) begin
      v = 24'($urandom());
    end else if (mode == MODE_EXTREME) begin
      v = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      case (idx)
        REG_PITCH_CODE_LOW: v = 24'($urandom_range(0, 20000));
        REG_HZ_PER_CODE:    v = 24'($urandom_range(0, 40000));
        REG_FREQ_LOW_HZ:    v = 24'($urandom_range(20, 2000));
        REG_FREQ_HIGH_HZ:   v = 24'($urandom_range(200, 20000));
        REG_GAIN_CODE_LOW:  v = 24'($urandom_range(0, 20000));
        REG_AMP_PER_CODE:   v = 24'($urandom_range(0, 4096));
        REG_STEP_PER_HZ:    v = 24'($urandom_range(0, 200000));
        default:            v = 24'($urandom());
      endcase
    end
    return v;
  endfunction

  // Result side: random stalls per sample, with burst stretches of none,
  // and two long hold-offs that back the block up into its input.
  initial begin : sample_sink
    int stall;
    int taken;
    bit rx_burst;
    taken = 0;
    rx_burst = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 18);
      if (taken == 300 || taken == 1300) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
      taken++;
    end
  end

  initial begin : frame_source
    int ph;
    int i;
    int mode;
    logic [CODE_W-1:0] pitch;
    logic [CODE_W-1:0] gain;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: code extremes, exact low marks, one below, one above
    send_frame(16'h0000, 16'h0000);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(RST_PITCH_CODE_LOW, RST_GAIN_CODE_LOW);
    send_frame(RST_PITCH_CODE_LOW - 16'd1, RST_GAIN_CODE_LOW - 16'd1);
    send_frame(RST_PITCH_CODE_LOW + 16'd1, RST_GAIN_CODE_LOW + 16'd1);
    send_frame(16'hFFFF, 16'h0000);
    send_frame(16'h0000, 16'hFFFF);
    send_frame(16'd1000, 16'd20000);
    send_frame(16'd5000, 16'd30000);

    // Slopes, step, high limit fed all-ones 24-bit data; lows at zero
    wait_drained();
    write_reg(REG_PITCH_CODE_LOW, '0);
    write_reg(REG_HZ_PER_CODE, '1);
    write_reg(REG_FREQ_LOW_HZ, '0);
    write_reg(REG_FREQ_HIGH_HZ, '1);
    write_reg(REG_GAIN_CODE_LOW, '0);
    write_reg(REG_AMP_PER_CODE, '1);
    write_reg(REG_STEP_PER_HZ, '1);
    settings_count++;
    send_frame(16'h0000, 16'h0000);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'h0001, 16'h0001);
    send_frame(16'h8000, 16'h8000);

    // Reversed limits: low wins below the pitch low mark, else high wins
    wait_drained();
    write_reg(REG_PITCH_CODE_LOW, 24'(RST_PITCH_CODE_LOW));
    write_reg(REG_HZ_PER_CODE, RST_HZ_PER_CODE);
    write_reg(REG_FREQ_LOW_HZ, 24'd5000);
    write_reg(REG_FREQ_HIGH_HZ, 24'd200);
    write_reg(REG_GAIN_CODE_LOW, 24'(RST_GAIN_CODE_LOW));
    write_reg(REG_AMP_PER_CODE, 24'(RST_AMP_PER_CODE));
    write_reg(REG_STEP_PER_HZ, RST_STEP_PER_HZ);
    settings_count++;
    send_frame(16'h0000, 16'h4000);
    send_frame(16'hFFFF, 16'hC000);
    send_frame(16'd30000, 16'hFFFF);

    // Zero slopes and zero step: constant frequency, silence, frozen phase;
    // then a write to an index past the map, which must change nothing
    wait_drained();
    write_reg(REG_HZ_PER_CODE, '0);
    write_reg(REG_AMP_PER_CODE, '0);
    write_reg(REG_STEP_PER_HZ, '0);
    settings_count++;
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'h1234, 16'hABCD);
    wait_drained();
    write_reg(REG_UNUSED, '1);
    send_frame(16'h0000, 16'hFFFF);

    // Low marks at their top: every code sits at or below them
    wait_drained();
    write_reg(REG_PITCH_CODE_LOW, '1);
    write_reg(REG_GAIN_CODE_LOW, '1);
    write_reg(REG_AMP_PER_CODE, 24'(RST_AMP_PER_CODE));
    write_reg(REG_STEP_PER_HZ, RST_STEP_PER_HZ);
    settings_count++;
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'h0000, 16'h0000);

    // Random part: a fresh setting per phase, frames mostly full-range,
    // some aimed at the knees of the pitch and gain mappings
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      mode = (ph == 0) ? MODE_TYPICAL : $urandom_range(MODE_TYPICAL, MODE_MIXED);
      if ($urandom_range(0, 1)) write_reg(REG_UNUSED, 24'($urandom()));
      write_reg(REG_PITCH_CODE_LOW, draw_setting(REG_PITCH_CODE_LOW, mode));
      write_reg(REG_HZ_PER_CODE, draw_setting(REG_HZ_PER_CODE, mode));
      write_reg(REG_FREQ_LOW_HZ, draw_setting(REG_FREQ_LOW_HZ, mode));
      write_reg(REG_FREQ_HIGH_HZ, draw_setting(REG_FREQ_HIGH_HZ, mode));
      write_reg(REG_GAIN_CODE_LOW, draw_setting(REG_GAIN_CODE_LOW, mode));
      write_reg(REG_AMP_PER_CODE, draw_setting(REG_AMP_PER_CODE, mode));
      write_reg(REG_STEP_PER_HZ, draw_setting(REG_STEP_PER_HZ, mode));
      settings_count++;
      for (i = 0; i < FRAMES_PER_PHASE; i++) begin
        pitch = 16'($urandom());
        gain = 16'($urandom());
        case ($urandom_range(0, 9))
          0, 1: pitch = pitch_low_seen + 16'($urandom_range(0, 64)) - 16'd32;
          2, 3: gain = gain_low_seen + 16'($urandom_range(0, 64)) - 16'd32;
          4: begin
            pitch = $urandom_range(0, 1) ? '1 : '0;
            gain = $urandom_range(0, 1) ? '1 : '0;
          end
          default: ;
        endcase
        send_frame(pitch, gain);
      end
    end

    // Drain, then keep watching for anything stray to show up
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d frames over %0d register settings: clamps, knees, zero slopes,",
             frames_sent, settings_count);
    $display("ignored writes, random gaps on both sides and long output hold-offs.");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
